/* sv/dwa_pkg.sv */
// Shared constants, codes and controller/datapath types for the DFA word acceptor.
package dwa_pkg;

    localparam int STATE_W        = 4;
    localparam int SYMBOL_W       = 8;
    localparam int OP_W           = 3;
    localparam int EDGE_W         = SYMBOL_W + STATE_W;
    localparam int MASK_W         = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int NUM_STATES_DEF = 16;
    localparam int MAX_EDGES_DEF  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_START  = 3'd2,
        OP_SYMBOL = 3'd3,
        OP_END    = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'b0,
        CFG_FINAL_MASK  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic step;
    } dwa_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic need_search;
        logic search_end;
    } dwa_status_t;

endpackage

/* sv/dwa_item_if.sv */
// Input item channel: valid/ready handshake with operation and edge payload.
interface dwa_item_if;

    logic                          valid;
    logic                          ready;
    logic [dwa_pkg::OP_W-1:0]      operation;
    logic [dwa_pkg::SYMBOL_W-1:0]  symbol;
    logic [dwa_pkg::STATE_W-1:0]   from_state;
    logic [dwa_pkg::STATE_W-1:0]   to_state;

    modport source (output valid, output operation, output symbol, output from_state,
                    output to_state, input ready);
    modport sink   (input valid, input operation, input symbol, input from_state,
                    input to_state, output ready);

endinterface

/* sv/dwa_result_if.sv */
// Result channel: valid/ready handshake with verdict, error flag and current state.
interface dwa_result_if;

    logic                         valid;
    logic                         ready;
    logic                         verdict_valid;
    logic                         accepted;
    logic                         table_full;
    logic [dwa_pkg::STATE_W-1:0]  state_now;

    modport source (output valid, output verdict_valid, output accepted, output table_full,
                    output state_now, input ready);
    modport sink   (input valid, input verdict_valid, input accepted, input table_full,
                    input state_now, output ready);

endinterface

/* sv/dwa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dwa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/dwa_ctrl.sv */
// Controller state machine: sequences accept, execute and edge search.
module dwa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  dwa_pkg::dwa_status_t status,
    output dwa_pkg::dwa_cmd_t    cmd
);

    import dwa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && status.slot_free)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.need_search ? ST_SEARCH : ST_IDLE;
            end
            ST_SEARCH:
            begin
                state_next = status.search_end ? ST_IDLE : ST_SEARCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = status.slot_free;
                cmd.latch  = status.slot_free && item_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // search is entered only from execute
    a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |->
            ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_SEARCH))
        else $error("search state entered without execute");

endmodule

/* sv/dwa_datapath.sv */
// Datapath: item latch, edge counts, edge table, automaton state and result register.
module dwa_datapath #(
    parameter int NUM_STATES = dwa_pkg::NUM_STATES_DEF,
    parameter int MAX_EDGES  = dwa_pkg::MAX_EDGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dwa_pkg::dwa_cmd_t              cmd,
    output dwa_pkg::dwa_status_t           status,
    input  logic [dwa_pkg::OP_W-1:0]       operation,
    input  logic [dwa_pkg::SYMBOL_W-1:0]   symbol,
    input  logic [dwa_pkg::STATE_W-1:0]    from_state,
    input  logic [dwa_pkg::STATE_W-1:0]    to_state,
    input  logic                           cfg_we,
    input  logic [dwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwa_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           verdict_valid,
    output logic                           accepted,
    output logic                           table_full,
    output logic [dwa_pkg::STATE_W-1:0]    state_now
);

    import dwa_pkg::*;

    localparam int SLOTS    = NUM_STATES * MAX_EDGES;
    localparam int ADDR_W   = $clog2(SLOTS);
    localparam int ST_IDX_W = $clog2(NUM_STATES);
    localparam int CNT_W    = $clog2(MAX_EDGES + 1);

    logic [OP_W-1:0]     op_reg;
    logic [SYMBOL_W-1:0] sym_reg;
    logic [STATE_W-1:0]  from_reg;
    logic [STATE_W-1:0]  to_reg;

    logic [STATE_W-1:0]  cur_reg, cur_next;
    logic                alive_reg, alive_next;
    logic [CNT_W-1:0]    cnt_reg [NUM_STATES];
    logic [CNT_W-1:0]    cnt_next [NUM_STATES];
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [STATE_W-1:0]  start_reg, start_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;

    logic                out_valid_reg, out_valid_next;
    logic                verdict_reg, verdict_next;
    logic                acc_reg, acc_next;
    logic                full_reg, full_next;
    logic [STATE_W-1:0]  state_now_reg, state_now_next;

    logic                from_ok;
    logic                cur_ok;
    logic [CNT_W-1:0]    from_cnt;
    logic [CNT_W-1:0]    cur_cnt;
    logic                add_full;
    logic                need_search;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    rd_idx;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    logic [EDGE_W-1:0]   rd_data;
    logic                hit;
    logic                last;
    logic                load;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            sym_reg  <= symbol;
            from_reg <= from_state;
            to_reg   <= to_state;
        end
    end

    assign from_ok     = 32'(from_reg) < 32'(NUM_STATES);
    assign cur_ok      = 32'(cur_reg) < 32'(NUM_STATES);
    assign from_cnt    = cnt_reg[ST_IDX_W'(from_reg)];
    assign cur_cnt     = cnt_reg[ST_IDX_W'(cur_reg)];
    assign add_full    = from_cnt == CNT_W'(MAX_EDGES);
    assign need_search = (op_t'(op_reg) == OP_SYMBOL) && alive_reg && cur_ok
                         && (cur_cnt != '0);
    assign idx_inc     = idx_reg + CNT_W'(1);
    assign rd_idx      = cmd.step ? idx_inc : '0;
    assign rd_addr     = ADDR_W'(cur_reg) * ADDR_W'(MAX_EDGES) + ADDR_W'(rd_idx);
    assign wr_addr     = ADDR_W'(from_reg) * ADDR_W'(MAX_EDGES) + ADDR_W'(from_cnt);
    assign wr_en       = cmd.exec && (op_t'(op_reg) == OP_ADD) && from_ok && !add_full;
    assign hit         = rd_data[EDGE_W-1:STATE_W] == sym_reg;
    assign last        = idx_inc == cur_cnt;

    dwa_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (SLOTS)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({sym_reg, to_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cur_next     = cur_reg;
        alive_next   = alive_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        load         = 1'b0;
        verdict_next = 1'b0;
        acc_next     = 1'b0;
        full_next    = 1'b0;

        if (cmd.exec)
        begin
            unique case (op_t'(op_reg))
                OP_CLEAR:
                begin
                    for (int i = 0; i < NUM_STATES; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    load = 1'b1;
                end
                OP_ADD:
                begin
                    if (from_ok)
                    begin
                        if (add_full)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next[ST_IDX_W'(from_reg)] = from_cnt + CNT_W'(1);
                        end
                    end
                    load = 1'b1;
                end
                OP_START:
                begin
                    cur_next   = start_reg;
                    alive_next = 1'b1;
                    load       = 1'b1;
                end
                OP_SYMBOL:
                begin
                    if (need_search)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        alive_next = 1'b0;
                        load       = 1'b1;
                    end
                end
                OP_END:
                begin
                    verdict_next = 1'b1;
                    acc_next     = alive_reg && mask_reg[cur_reg];
                    alive_next   = 1'b0;
                    load         = 1'b1;
                end
                default:
                begin
                    load = 1'b1;
                end
            endcase
        end

        if (cmd.step)
        begin
            if (hit)
            begin
                cur_next = rd_data[STATE_W-1:0];
                load     = 1'b1;
            end
            else if (last)
            begin
                alive_next = 1'b0;
                load       = 1'b1;
            end
            else
            begin
                idx_next = idx_inc;
            end
        end

        state_now_next = cur_next;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        start_next = start_reg;
        mask_next  = mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_START_STATE: start_next = cfg_data[STATE_W-1:0];
                CFG_FINAL_MASK:  mask_next  = cfg_data[MASK_W-1:0];
                default:         start_next = start_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            alive_reg     <= 1'b0;
            cnt_reg       <= '{default: '0};
            idx_reg       <= '0;
            start_reg     <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            alive_reg     <= alive_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg   <= verdict_next;
            acc_reg       <= acc_next;
            full_reg      <= full_next;
            state_now_reg <= state_now_next;
        end
    end

    assign status.slot_free   = !out_valid_reg || result_ready;
    assign status.need_search = need_search;
    assign status.search_end  = hit || last;

    assign result_valid  = out_valid_reg;
    assign verdict_valid = verdict_reg;
    assign accepted      = acc_reg;
    assign table_full    = full_reg;
    assign state_now     = state_now_reg;

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid_reg)
        else $error("result loaded over a pending result");

    a_step_alive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (alive_reg && cur_ok))
        else $error("edge search on a dead word or bad state");

    a_step_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (idx_reg < cur_cnt))
        else $error("edge search past the stored edge count");

endmodule

/* sv/dfa_word_acceptor.sv */
// Top level of the DFA word acceptor: controller, datapath and channel hookup.
//
// Items arrive on the item channel and each gives exactly one transfer on the
// result channel. Operations: clear table, add edge, start word, symbol, end word.
// start_state and final_state_mask are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
//
// Result: the result register loads in the cycle after the item transfer for
// every operation except a symbol that searches the edge list; such a symbol
// first steps through the stored edges of the current state until a match or
// the last edge. The search reads the edge table RAM one entry a cycle through
// its registered read port. Flow: one item at a time; a new item is taken once
// the result register is empty or being drained.
//
// Reset clears the automaton state, edge counts, configuration and result valid;
// the edge table itself needs no clearing. A stalled receiver holds the result and
// the block takes no further item until that result is transferred.
module dfa_word_acceptor #(
    parameter int NUM_STATES = dwa_pkg::NUM_STATES_DEF,
    parameter int MAX_EDGES  = dwa_pkg::MAX_EDGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwa_pkg::CFG_DATA_W-1:0] cfg_data,
    dwa_item_if.sink                       item,
    dwa_result_if.source                   result
);

    import dwa_pkg::*;

    dwa_cmd_t    cmd;
    dwa_status_t status;

    dwa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    dwa_datapath #(
        .NUM_STATES (NUM_STATES),
        .MAX_EDGES  (MAX_EDGES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (item.operation),
        .symbol        (item.symbol),
        .from_state    (item.from_state),
        .to_state      (item.to_state),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .verdict_valid (result.verdict_valid),
        .accepted      (result.accepted),
        .table_full    (result.table_full),
        .state_now     (result.state_now)
    );

endmodule
